// ===== design/kli_pkg.sv =====
// shared types and constants for the keyframe linear interpolator
// no dependencies
package kli_pkg;

    localparam int unsigned VAL_W  = 32;
    localparam int unsigned FRAC_W = 16;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_COUNT = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef logic signed [VAL_W-1:0] val_t;

    // four components of one keypoint
    typedef struct packed {
        val_t x;
        val_t y;
        val_t z;
        val_t w;
    } vec_t;

endpackage

// ===== design/keyframe_linear_interpolator_top.sv =====
// top level of the keyframe linear interpolator: keypoint memories, scan
// sequencer, chain of division cells and four lerp cells; depends on kli_pkg
//
//  channel | ports               | direction | beat carries
//  input   | s_valid / s_ready   | in        | kind, variable, slot, time, x..w
//  result  | m_valid / m_ready   | out       | present, out_x..out_w
//
// load and set-count beats are taken in idle, and an empty query goes
// straight to the result; a query scans keypoints one per cycle, reads the
// two chosen keypoints, runs the division chain and the lerp cells, then
// registers the result; no new beat is taken until the result is taken
// reset (aresetn, synchronous) clears counts and control; keypoint memories
// hold garbage until loaded; a stalled result holds in the output register
module keyframe_linear_interpolator_top #(
    parameter int NUM_VARIABLES = 16,
    parameter int MAX_KEYS      = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_kind,
    input  logic [3:0]          s_variable,
    input  logic [6:0]          s_slot,
    input  kli_pkg::val_t       s_point_time,
    input  kli_pkg::val_t       s_load_x,
    input  kli_pkg::val_t       s_load_y,
    input  kli_pkg::val_t       s_load_z,
    input  kli_pkg::val_t       s_load_w,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_present,
    output kli_pkg::val_t       m_out_x,
    output kli_pkg::val_t       m_out_y,
    output kli_pkg::val_t       m_out_z,
    output kli_pkg::val_t       m_out_w
);
    import kli_pkg::*;

    localparam int VW    = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;
    localparam int KW    = $clog2(MAX_KEYS);
    localparam int CW    = $clog2(MAX_KEYS + 1);
    localparam int AW    = VW + KW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_LERP  = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // keypoint memories
    val_t mem_t   [DEPTH];
    vec_t mem_v   [DEPTH];
    logic [CW-1:0] count_reg [NUM_VARIABLES];

    logic [AW-1:0]  rd_addr;
    val_t           rd_t;
    vec_t           rd_v;

    // query context
    logic [VW-1:0]  var_reg;
    val_t           qt_reg;
    logic [CW-1:0]  n_reg;
    logic [CW-1:0]  idx_reg;
    logic           pend_reg;     // a read was issued last cycle
    logic [CW-1:0]  pend_idx_reg;
    logic [1:0]     rd_phase_reg;
    logic [KW-1:0]  ip_reg, inx_reg;
    val_t           tp_reg, tn_reg;
    vec_t           vp_reg, vn_reg;
    logic [4:0]     cnt_reg;
    logic [15:0]    frac_reg;

    logic in_fire, var_ok;
    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;
    assign var_ok  = ({28'd0, s_variable} < 32'(NUM_VARIABLES));

    logic [VW-1:0] s_var_idx;
    assign s_var_idx = VW'(s_variable);

    // memory writes and registered reads
    always_ff @(posedge aclk) begin
        if (in_fire && kind_t'(s_kind) == KIND_LOAD && var_ok
                && {25'd0, s_slot} < 32'(MAX_KEYS)) begin
            mem_t[{s_var_idx, KW'(s_slot)}] <= s_point_time;
            mem_v[{s_var_idx, KW'(s_slot)}] <= '{s_load_x, s_load_y, s_load_z, s_load_w};
        end
        rd_t <= mem_t[rd_addr];
        rd_v <= mem_v[rd_addr];
    end

    // keypoint counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_VARIABLES; k++) count_reg[k] <= '0;
        end else if (in_fire && kind_t'(s_kind) == KIND_COUNT && var_ok) begin
            count_reg[s_var_idx] <= ({25'd0, s_slot} > 32'(MAX_KEYS))
                ? CW'(MAX_KEYS) : CW'(s_slot);
        end
    end

    // scan address, then reads of prev and next keypoints
    always_comb begin
        rd_addr = {var_reg, idx_reg[KW-1:0]};
        if (state_reg == ST_READ)
            rd_addr = (rd_phase_reg == 2'd0) ? {var_reg, ip_reg} : {var_reg, inx_reg};
    end

    // division chain: 16 cells, loaded in the first cycle of ST_DIV,
    // quotient taken from the last cell at the end of ST_DIV
    logic signed [33:0] num_w, den_w;
    assign num_w = 34'(qt_reg) - 34'(tp_reg);
    assign den_w = 34'(tn_reg) - 34'(tp_reg);

    logic [32:0] rem0_reg;
    logic [15:0] q0_reg;
    logic [32:0] rem_c [17];
    logic [15:0] q_c   [17];
    logic        div_en;
    assign div_en   = (state_reg == ST_DIV);
    assign rem_c[0] = rem0_reg;
    assign q_c[0]   = q0_reg;
    always_ff @(posedge aclk) begin
        if (div_en && cnt_reg == 5'd0) begin
            rem0_reg <= num_w[32:0];
            q0_reg   <= '0;
        end
    end
    for (genvar g = 0; g < 16; g++) begin : g_div
        kli_div_cell u_cell (
            .aclk   (aclk),
            .en     (div_en),
            .rem_in (rem_c[g]),
            .den    (den_w[32:0]),
            .q_in   (q_c[g]),
            .rem_out(rem_c[g+1]),
            .q_out  (q_c[g+1])
        );
    end

    // lerp cells
    logic [1:0] lphase;
    val_t       lres_x, lres_y, lres_z, lres_w;
    assign lphase = (state_reg == ST_LERP) ? cnt_reg[1:0] : 2'd3;
    kli_lerp_cell u_lx (.aclk(aclk), .phase(lphase), .a(vp_reg.x), .b(vn_reg.x),
                        .frac(frac_reg), .result(lres_x));
    kli_lerp_cell u_ly (.aclk(aclk), .phase(lphase), .a(vp_reg.y), .b(vn_reg.y),
                        .frac(frac_reg), .result(lres_y));
    kli_lerp_cell u_lz (.aclk(aclk), .phase(lphase), .a(vp_reg.z), .b(vn_reg.z),
                        .frac(frac_reg), .result(lres_z));
    kli_lerp_cell u_lw (.aclk(aclk), .phase(lphase), .a(vp_reg.w), .b(vn_reg.w),
                        .frac(frac_reg), .result(lres_w));

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire && kind_t'(s_kind) == KIND_QUERY) begin
                if (!var_ok || count_reg[s_var_idx] == '0) state_next = ST_OUT;
                else                                         state_next = ST_SCAN;
            end
            ST_SCAN: if (pend_reg && (rd_t > qt_reg || pend_idx_reg == n_reg - 1'b1))
                state_next = ST_READ;
            ST_READ: if (rd_phase_reg == 2'd2) state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 5'd17) state_next = ST_LERP;
            ST_LERP: if (cnt_reg == 5'd3) state_next = ST_DONE;
            ST_DONE: state_next = ST_OUT;
            ST_OUT:  if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    logic [CW-1:0] i_found;
    assign i_found = (rd_t > qt_reg) ? pend_idx_reg : n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid   <= (state_next == ST_OUT);
            unique case (state_reg)
                ST_IDLE: begin
                    var_reg      <= VW'(s_variable);
                    qt_reg       <= s_point_time;
                    n_reg        <= var_ok ? count_reg[s_var_idx] : '0;
                    idx_reg      <= '0;
                    pend_reg     <= 1'b0;
                    rd_phase_reg <= '0;
                    cnt_reg      <= '0;
                    m_present    <= 1'b0;
                    m_out_x      <= '0;
                    m_out_y      <= '0;
                    m_out_z      <= '0;
                    m_out_w      <= '0;
                end
                ST_SCAN: begin
                    pend_reg     <= 1'b1;
                    pend_idx_reg <= idx_reg;
                    idx_reg      <= idx_reg + 1'b1;
                    if (pend_reg) begin
                        ip_reg  <= (i_found != '0) ? KW'(i_found - 1'b1) : '0;
                        inx_reg <= (i_found < n_reg) ? KW'(i_found) : KW'(n_reg - 1'b1);
                    end
                end
                ST_READ: begin
                    rd_phase_reg <= rd_phase_reg + 1'b1;
                    if (rd_phase_reg == 2'd1) begin
                        tp_reg <= rd_t;
                        vp_reg <= rd_v;
                    end
                    if (rd_phase_reg == 2'd2) begin
                        tn_reg <= rd_t;
                        vn_reg <= rd_v;
                    end
                end
                ST_DIV: begin
                    cnt_reg <= (cnt_reg == 5'd17) ? 5'd0 : cnt_reg + 1'b1;
                    if (cnt_reg == 5'd17)
                        frac_reg <= ((den_w <= 0) || (num_w <= 0)) ? 16'd0
                                  : (num_w >= den_w) ? 16'hFFFF : q_c[16];
                end
                ST_LERP: cnt_reg <= cnt_reg + 1'b1;
                ST_DONE: begin
                    m_present <= 1'b1;
                    m_out_x   <= lres_x;
                    m_out_y   <= lres_y;
                    m_out_z   <= lres_z;
                    m_out_w   <= lres_w;
                end
                ST_OUT: ;
                default: ;
            endcase
        end
    end
endmodule

// ===== design/kli_div_cell.sv =====
// one restoring division step cell: shift, trial subtract, quotient bit
// depends on kli_pkg
module kli_div_cell (
    input  logic        aclk,
    input  logic        en,
    input  logic [32:0] rem_in,
    input  logic [32:0] den,
    input  logic [15:0] q_in,
    output logic [32:0] rem_out,
    output logic [15:0] q_out
);
    import kli_pkg::*;

    logic [33:0] shifted;
    logic [33:0] diff;

    assign shifted = {rem_in, 1'b0};
    assign diff    = shifted - {1'b0, den};

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!diff[33]) begin
                rem_out <= diff[32:0];
                q_out   <= {q_in[14:0], 1'b1};
            end else begin
                rem_out <= shifted[32:0];
                q_out   <= {q_in[14:0], 1'b0};
            end
        end
    end
endmodule

// ===== design/kli_lerp_cell.sv =====
// one component lerp cell: difference, product with fraction, floor shift, add
// depends on kli_pkg
module kli_lerp_cell (
    input  logic                aclk,
    input  logic [1:0]          phase,
    input  kli_pkg::val_t       a,
    input  kli_pkg::val_t       b,
    input  logic [15:0]         frac,
    output kli_pkg::val_t       result
);
    import kli_pkg::*;

    logic signed [32:0] diff_reg;
    logic signed [49:0] prod_reg;
    logic signed [49:0] prod_next;

    assign prod_next = diff_reg * $signed({1'b0, frac});

    always_ff @(posedge aclk) begin
        unique case (phase)
            2'd0: diff_reg <= 33'(b) - 33'(a);
            2'd1: prod_reg <= prod_next;
            2'd2: result   <= val_t'(a + val_t'(prod_reg >>> FRAC_W));
            default: ;
        endcase
    end
endmodule

// ===== dv/testbench.sv =====
// self-checking bench for keyframe_linear_interpolator_top: keypoint loads,
// count updates and interpolation queries checked against a built-in predictor
// depends on kli_pkg and the top level
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kli_pkg::*;

    localparam int NVAR       = 16;
    localparam int NKEY       = 64;
    localparam int CYCLE_CAP  = 1500000;

    typedef struct {
        logic present;
        val_t x;
        val_t y;
        val_t z;
        val_t w;
    } lerp_result_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_kind;
    logic [3:0] s_variable;
    logic [6:0] s_slot;
    val_t       s_point_time;
    val_t       s_load_x;
    val_t       s_load_y;
    val_t       s_load_z;
    val_t       s_load_w;
    logic       m_valid;
    logic       m_ready;
    logic       m_present;
    val_t       m_out_x;
    val_t       m_out_y;
    val_t       m_out_z;
    val_t       m_out_w;

    keyframe_linear_interpolator_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_variable   (s_variable),
        .s_slot       (s_slot),
        .s_point_time (s_point_time),
        .s_load_x     (s_load_x),
        .s_load_y     (s_load_y),
        .s_load_z     (s_load_z),
        .s_load_w     (s_load_w),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_present    (m_present),
        .m_out_x      (m_out_x),
        .m_out_y      (m_out_y),
        .m_out_z      (m_out_z),
        .m_out_w      (m_out_w)
    );

    // shadow copy of the keypoint table
    val_t        shadow_time [NVAR][NKEY];
    val_t        shadow_x    [NVAR][NKEY];
    val_t        shadow_y    [NVAR][NKEY];
    val_t        shadow_z    [NVAR][NKEY];
    val_t        shadow_w    [NVAR][NKEY];
    bit          loaded      [NVAR][NKEY];
    int unsigned shadow_count[NVAR];

    lerp_result_t pending_lerps[$];

    bit          no_idle;
    int unsigned error_count;
    int unsigned query_count;
    int unsigned beat_count;
    int unsigned cycle_count;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // restoring division, one quotient bit per step
    function automatic int unsigned lerp_fraction(longint num, longint den);
        longint      rem;
        int unsigned q;
        rem = num;
        q   = 0;
        if (den <= 0 || num <= 0) return 0;
        if (num >= den) return 16'hFFFF;
        for (int k = 0; k < 16; k++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q   = q | 1;
            end
        end
        return q;
    endfunction

    // arithmetic shift gives the floor of the scaled product
    function automatic val_t lerp_component(val_t a, val_t b, int unsigned frac);
        longint p;
        longint r;
        p = (longint'(b) - longint'(a)) * longint'(frac);
        r = longint'(a) + (p >>> 16);
        return r[31:0];
    endfunction

    function automatic lerp_result_t interpolate(int v, val_t t);
        lerp_result_t res;
        int           n;
        int           i;
        int           ip;
        int           inx;
        int unsigned  frac;
        res = '{1'b0, 0, 0, 0, 0};
        n   = shadow_count[v];
        if (n == 0) return res;
        for (i = 0; i < n; i++)
            if (shadow_time[v][i] > t) break;
        ip   = (i > 0) ? i - 1 : 0;
        inx  = (i < n) ? i : n - 1;
        frac = lerp_fraction(longint'(t) - longint'(shadow_time[v][ip]),
                             longint'(shadow_time[v][inx]) - longint'(shadow_time[v][ip]));
        res.present = 1'b1;
        res.x = lerp_component(shadow_x[v][ip], shadow_x[v][inx], frac);
        res.y = lerp_component(shadow_y[v][ip], shadow_y[v][inx], frac);
        res.z = lerp_component(shadow_z[v][ip], shadow_z[v][inx], frac);
        res.w = lerp_component(shadow_w[v][ip], shadow_w[v][inx], frac);
        return res;
    endfunction

    // a query may only touch keypoints that were loaded
    function automatic bit query_safe(int v);
        for (int i = 0; i < shadow_count[v]; i++)
            if (!loaded[v][i]) return 0;
        return 1;
    endfunction

    // drive one beat, wait for the handshake, then update the shadow table
    task automatic send_beat(kind_t k, int v, int sl, val_t t,
                             val_t x = 0, val_t y = 0, val_t z = 0, val_t w = 0);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 22) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid      <= 1'b1;
        s_kind       <= k;
        s_variable   <= v[3:0];
        s_slot       <= sl[6:0];
        s_point_time <= t;
        s_load_x     <= x;
        s_load_y     <= y;
        s_load_z     <= z;
        s_load_w     <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beat_count++;
        case (k)
            KIND_LOAD: begin
                if (sl < NKEY) begin
                    shadow_time[v][sl] = t;
                    shadow_x[v][sl]    = x;
                    shadow_y[v][sl]    = y;
                    shadow_z[v][sl]    = z;
                    shadow_w[v][sl]    = w;
                    loaded[v][sl]      = 1'b1;
                end
            end
            KIND_COUNT: shadow_count[v] = (sl > NKEY) ? NKEY : sl;
            KIND_QUERY: begin
                pending_lerps = {pending_lerps, interpolate(v, t)};
                query_count++;
            end
            default: ;
        endcase
    endtask

    task automatic query_if_safe(int v, val_t t);
        if (query_safe(v)) send_beat(KIND_QUERY, v, $urandom_range(0, 127), t);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_lerps.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // extremes, edge positions in the table and ignored beats
    task automatic test_directed();
        val_t vmax;
        val_t vmin;
        vmax = 32'sh7FFFFFFF;
        vmin = 32'sh80000000;
        // empty variable
        send_beat(KIND_QUERY, 0, 0, 0);
        send_beat(KIND_LOAD, 0, 0, vmin, vmin, vmax, 0, -1);
        send_beat(KIND_LOAD, 0, 1, 0, vmax, vmin, 32'sh00010000, 1);
        send_beat(KIND_LOAD, 0, 2, 0, 5, 6, 7, 8);
        send_beat(KIND_LOAD, 0, 3, vmax, vmin, vmax, -5, vmin);
        send_beat(KIND_COUNT, 0, 4, 0);
        send_beat(KIND_QUERY, 0, 0, vmin);
        send_beat(KIND_QUERY, 0, 0, vmin + 1);
        send_beat(KIND_QUERY, 0, 0, -1);
        send_beat(KIND_QUERY, 0, 0, 0);
        send_beat(KIND_QUERY, 0, 0, 32'sh40000000);
        send_beat(KIND_QUERY, 0, 0, vmax);
        // keypoints out of time order
        send_beat(KIND_LOAD, 1, 0, 32'sh00050000, 100, 200, 300, 400);
        send_beat(KIND_LOAD, 1, 1, 32'sh00010000, -100, -200, -300, -400);
        send_beat(KIND_COUNT, 1, 2, 0);
        send_beat(KIND_QUERY, 1, 0, 32'sh00030000);
        send_beat(KIND_QUERY, 1, 0, 32'sh00070000);
        // ignored beats: unknown kind, load past the table
        send_beat(KIND_NONE, 15, 127, -1, -1, -1, -1, -1);
        send_beat(KIND_LOAD, 1, 64, 0, 9, 9, 9, 9);
        send_beat(KIND_LOAD, 1, 127, 0, 9, 9, 9, 9);
        send_beat(KIND_QUERY, 1, 0, 32'sh00020000);
        // count saturates, then drops back to empty
        send_beat(KIND_COUNT, 14, 127, 0);
        send_beat(KIND_COUNT, 14, 0, 0);
        send_beat(KIND_QUERY, 14, 0, vmax);
    endtask

    // well-formed keypoint sets with random content, plus noise
    task automatic test_random(int unsigned target);
        int   v;
        int   n;
        int   nq;
        int   cnt;
        val_t t;
        val_t t_first;
        int   r;
        while (beat_count < target) begin
            // long stretch with no idling in the middle
            no_idle = (beat_count > target / 2) && (beat_count < target / 2 + 250);
            v = $urandom_range(0, NVAR - 1);
            r = $urandom_range(0, 99);
            if (r < 10) begin
                case ($urandom_range(0, 3))
                    0: send_beat(KIND_NONE, v, $urandom_range(0, 127), $urandom,
                                 $urandom, $urandom, $urandom, $urandom);
                    1: send_beat(KIND_LOAD, v, $urandom_range(64, 127), $urandom,
                                 $urandom, $urandom, $urandom, $urandom);
                    2: send_beat(KIND_COUNT, v, 0, $urandom);
                    default: query_if_safe(v, $urandom);
                endcase
                continue;
            end
            n = (r < 16) ? NKEY : $urandom_range(1, 6);
            t = (r < 50) ? $urandom : $urandom_range(0, 1000) - 500;
            t_first = t;
            for (int i = 0; i < n; i++) begin
                send_beat(KIND_LOAD, v, i, t, $urandom, $urandom, $urandom, $urandom);
                if ($urandom_range(0, 9) == 0)
                    t = $urandom;
                else if ($urandom_range(0, 4) != 0)
                    t = (t > 32'sh70000000) ? t : t + $urandom_range(0, 32'h00100000);
            end
            cnt = (n == NKEY) ? $urandom_range(NKEY, 127) : n;
            send_beat(KIND_COUNT, v, cnt, $urandom);
            nq = $urandom_range(2, 6);
            for (int q = 0; q < nq; q++) begin
                if ($urandom_range(0, 3) == 0)
                    query_if_safe(v, $urandom);
                else
                    query_if_safe(v, t_first + $urandom_range(0, 32'h00400000) - 32'h00080000);
            end
        end
        no_idle = 1'b0;
    endtask

    // sender holds off until every pending result has been returned
    task automatic test_drain_pause();
        wait_drained();
        for (int v = 0; v < NVAR; v++) query_if_safe(v, $urandom);
    endtask

    // result checker
    always @(posedge aclk) begin
        lerp_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_lerps.size() == 0) begin
                $display("%0t: unexpected result present=%0b x=%h", $time, m_present, m_out_x);
                error_count++;
            end else begin
                exp_res = pending_lerps.pop_front();
                if (m_present !== exp_res.present) begin
                    $display("%0t: present expected %0b actual %0b", $time,
                             exp_res.present, m_present);
                    error_count++;
                end
                if (m_out_x !== exp_res.x) begin
                    $display("%0t: out_x expected %h actual %h", $time, exp_res.x, m_out_x);
                    error_count++;
                end
                if (m_out_y !== exp_res.y) begin
                    $display("%0t: out_y expected %h actual %h", $time, exp_res.y, m_out_y);
                    error_count++;
                end
                if (m_out_z !== exp_res.z) begin
                    $display("%0t: out_z expected %h actual %h", $time, exp_res.z, m_out_z);
                    error_count++;
                end
                if (m_out_w !== exp_res.w) begin
                    $display("%0t: out_w expected %h actual %h", $time, exp_res.w, m_out_w);
                    error_count++;
                end
            end
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= 22);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("keyframe_linear_interpolator_top test failed");
            $finish;
        end
    end

    initial begin
        error_count  = 0;
        query_count  = 0;
        beat_count   = 0;
        cycle_count  = 0;
        no_idle      = 1'b0;
        for (int v = 0; v < NVAR; v++) begin
            shadow_count[v] = 0;
            for (int i = 0; i < NKEY; i++) loaded[v][i] = 1'b0;
        end
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_kind       = KIND_NONE;
        s_variable   = '0;
        s_slot       = '0;
        s_point_time = '0;
        s_load_x     = '0;
        s_load_y     = '0;
        s_load_z     = '0;
        s_load_w     = '0;
        m_ready      = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(700);
        test_drain_pause();
        test_random(1450);
        wait_drained();

        $display("covered %0d beats and %0d interpolation queries", beat_count, query_count);
        $display("loads, count updates, ignored beats, empty and full tables, stalls");
        if (error_count == 0) begin
            $display("keyframe_linear_interpolator_top test passed");
        end else begin
            $display("keyframe_linear_interpolator_top test failed");
        end
        $finish;
    end

endmodule
